/* rtl/dcf_pkg.sv */
// Shared types, codes and character classes for the delimited command framer.
package dcf_pkg;

  // Input command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_ANALYSE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Result item kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_ARG    = 2'd2;

  // Status codes
  localparam logic [3:0] ST_ACCEPTED  = 4'd0;
  localparam logic [3:0] ST_DROPPED   = 4'd1;
  localparam logic [3:0] ST_FORBIDDEN = 4'd2;
  localparam logic [3:0] ST_CLEARED   = 4'd3;
  localparam logic [3:0] ST_NO_END    = 4'd4;
  localparam logic [3:0] ST_EMPTY     = 4'd5;
  localparam logic [3:0] ST_NO_CMD    = 4'd6;
  localparam logic [3:0] ST_SPLIT_MSG = 4'd7;
  localparam logic [3:0] ST_NO_SPLIT  = 4'd8;

  // Configuration register indexes and reset values
  localparam logic CFG_END   = 1'b0;
  localparam logic CFG_SPLIT = 1'b1;
  localparam logic [7:0] END_CHAR_RESET   = 8'd10;
  localparam logic [7:0] SPLIT_CHAR_RESET = 8'd58;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_DECIDE   = 6'b001000,
    S_EMIT_RD  = 6'b010000,
    S_EMIT_OUT = 6'b100000
  } dcf_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       push;
    logic       clear;
    logic       scan_start;
    logic       scan_cmp;
    logic       emit_start;
    logic       emit_skip;
    logic       emit_ld;
    logic       rd;
    logic       drop_one;
    logic       drop_msg;
    logic       ld_status;
    logic [3:0] status_code;
  } dcf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic off_at_fill;
    logic hit_end;
    logic e_zero;
    logic s_zero;
    logic at_split;
    logic emit_last;
  } dcf_stat_t;

  // Letters, digits and '.'
  function automatic logic char_is_legal(input logic [7:0] c);
    return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
           (c == CHAR_DOT);
  endfunction

endpackage

/* rtl/dcf_ctrl.sv */
// Controller state machine of the delimited command framer.
module dcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  dcf_pkg::dcf_stat_t stat_i,
  output dcf_pkg::dcf_cmd_t  cmd_o
);
  import dcf_pkg::*;

  dcf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.out_free) begin
          case (command_i)
            CMD_PUSH: begin
              cmd_o.push = 1'b1;
            end
            CMD_CLEAR: begin
              cmd_o.clear       = 1'b1;
              cmd_o.ld_status   = 1'b1;
              cmd_o.status_code = ST_CLEARED;
            end
            CMD_ANALYSE: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN_RD;
            end
            default: begin
              cmd_o.ld_status   = 1'b1;
              cmd_o.status_code = ST_FORBIDDEN;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat_i.off_at_fill) begin
          // whole buffer scanned without an end character
          if (stat_i.out_free) begin
            cmd_o.ld_status   = 1'b1;
            cmd_o.status_code = ST_NO_END;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = stat_i.hit_end ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          if (stat_i.e_zero) begin
            cmd_o.drop_one    = 1'b1;
            cmd_o.ld_status   = 1'b1;
            cmd_o.status_code = ST_EMPTY;
            state_d           = S_IDLE;
          end else if (stat_i.s_zero) begin
            cmd_o.drop_msg    = 1'b1;
            cmd_o.ld_status   = 1'b1;
            cmd_o.status_code = ST_NO_CMD;
            state_d           = S_IDLE;
          end else begin
            cmd_o.emit_start = 1'b1;
            state_d          = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        // skip the split character itself
        if (stat_i.at_split) begin
          cmd_o.emit_skip = 1'b1;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.drop_msg = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dcf_dpath.sv */
// Datapath of the delimited command framer: character store, pointers and result register.
module dcf_dpath #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcf_pkg::dcf_cmd_t  cmd_i,
  output dcf_pkg::dcf_stat_t stat_o,
  input  logic [7:0]         char_in_i,
  input  logic [7:0]         end_char_i,
  input  logic [7:0]         split_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         item_kind_o,
  output logic [7:0]         data_byte_o,
  output logic [3:0]         status_o,
  output logic               last_o
);
  import dcf_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int SW = CW + 1;

  // (base + ofs) modulo depth, ofs never above the depth
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(BUFFER_DEPTH)) begin
      sum = sum - SW'(BUFFER_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  logic [7:0]    store_mem [BUFFER_DEPTH];
  logic [7:0]    rdata_q;

  logic [PW-1:0] rp_q, rp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] off_q, off_d;
  logic [CW-1:0] e_q, e_d;
  logic [CW-1:0] s_q, s_d;
  logic          found_s_q, found_s_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    data_q, data_d;
  logic [3:0]    status_q, status_d;
  logic          last_q, last_d;

  logic          full;
  logic          allowed;
  logic          do_write;
  logic [3:0]    push_status;
  logic          hit_split;
  logic          emit_last;
  logic [CW-1:0] msg_len;

  assign full      = (fill_q == CW'(BUFFER_DEPTH));
  assign allowed   = char_is_legal(char_in_i) || (char_in_i == end_char_i) ||
                     (char_in_i == split_char_i);
  assign do_write  = cmd_i.push && allowed;
  assign hit_split = (rdata_q == split_char_i);
  assign msg_len   = e_q + CW'(1);

  always_comb begin
    if (!allowed) begin
      push_status = ST_FORBIDDEN;
    end else if (full) begin
      push_status = ST_DROPPED;
    end else begin
      push_status = ST_ACCEPTED;
    end
  end

  // Final byte sits just before the end, or before the split when the argument is empty
  assign emit_last = ((SW'(off_q) + SW'(1)) == SW'(e_q)) ||
                     (found_s_q && ((SW'(s_q) + SW'(1)) == SW'(e_q)) &&
                      ((SW'(off_q) + SW'(2)) == SW'(e_q)));

  always_comb begin
    stat_o.out_free    = !out_valid_q || !out_stall_i;
    stat_o.off_at_fill = (off_q == fill_q);
    stat_o.hit_end     = (rdata_q == end_char_i);
    stat_o.e_zero      = (e_q == '0);
    stat_o.s_zero      = found_s_q && (s_q == '0);
    stat_o.at_split    = found_s_q && (off_q == s_q);
    stat_o.emit_last   = emit_last;
  end

  // Character store with registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_mem[wrap_add(rp_q, fill_q)] <= char_in_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_mem[wrap_add(rp_q, off_q)];
    end
  end

  always_comb begin
    rp_d   = rp_q;
    fill_d = fill_q;
    if (cmd_i.clear) begin
      rp_d   = '0;
      fill_d = '0;
    end else if (do_write) begin
      // full: drop the oldest byte, count stays at depth
      if (full) begin
        rp_d = wrap_add(rp_q, CW'(1));
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end else if (cmd_i.drop_one) begin
      rp_d   = wrap_add(rp_q, CW'(1));
      fill_d = fill_q - CW'(1);
    end else if (cmd_i.drop_msg) begin
      rp_d   = wrap_add(rp_q, msg_len);
      fill_d = fill_q - msg_len;
    end
  end

  always_comb begin
    off_d     = off_q;
    e_d       = e_q;
    s_d       = s_q;
    found_s_d = found_s_q;
    if (cmd_i.scan_start) begin
      off_d     = '0;
      found_s_d = 1'b0;
    end else if (cmd_i.emit_start) begin
      off_d = '0;
    end else if (cmd_i.scan_cmp) begin
      off_d = off_q + CW'(1);
      if (stat_o.hit_end) begin
        e_d = off_q;
      end
      if (hit_split && !found_s_q) begin
        s_d       = off_q;
        found_s_d = 1'b1;
      end
    end else if (cmd_i.emit_skip || cmd_i.emit_ld) begin
      off_d = off_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    data_d      = data_q;
    status_d    = status_q;
    last_d      = last_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_STATUS;
      data_d      = '0;
      status_d    = push_status;
      last_d      = 1'b1;
    end else if (cmd_i.ld_status) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_STATUS;
      data_d      = '0;
      status_d    = cmd_i.status_code;
      last_d      = 1'b1;
    end else if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
      kind_d      = (found_s_q && (off_q > s_q)) ? KIND_ARG : KIND_CMD;
      data_d      = rdata_q;
      status_d    = found_s_q ? ST_SPLIT_MSG : ST_NO_SPLIT;
      last_d      = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      fill_q      <= '0;
      off_q       <= '0;
      e_q         <= '0;
      s_q         <= '0;
      found_s_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      off_q       <= off_d;
      e_q         <= e_d;
      s_q         <= s_d;
      found_s_q   <= found_s_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign item_kind_o = kind_q;
  assign data_byte_o = data_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

/* rtl/delimited_command_framer_unit.sv */
// Top level of the delimited command framer: configuration registers, controller and datapath.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   command_i, char_in_i
//  out      output     out_valid_o / out_stall_i item_kind_o, data_byte_o, status_o, last_o
//  cfg      APB        psel/penable/pwrite       paddr, pwdata, prdata (end, split)
//
// Push, clear and the unknown command each give one result.
// Analyse scans the store through its single registered read port, reading then
// comparing each byte up to the end character, decides, then reads and outputs
// each emitted byte and steps over the split; one item is in work at a time.
// Reset empties the buffer at once; store contents stay undefined until pushed.
// A stalled result holds in the output register; input is taken once it drains.
module delimited_command_framer_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  status_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcf_pkg::*;

  logic [7:0] end_char_q, end_char_d;
  logic [7:0] split_char_q, split_char_d;
  logic       cfg_write;
  dcf_cmd_t   cmd;
  dcf_stat_t  stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    end_char_d   = end_char_q;
    split_char_d = split_char_q;
    if (cfg_write) begin
      case (paddr[2])
        CFG_END:   end_char_d   = pwdata[7:0];
        CFG_SPLIT: split_char_d = pwdata[7:0];
        default:   end_char_d   = end_char_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_END:   prdata = {24'd0, end_char_q};
      CFG_SPLIT: prdata = {24'd0, split_char_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char_q   <= END_CHAR_RESET;
      split_char_q <= SPLIT_CHAR_RESET;
    end else begin
      end_char_q   <= end_char_d;
      split_char_q <= split_char_d;
    end
  end

  dcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dcf_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .char_in_i    (char_in_i),
    .end_char_i   (end_char_q),
    .split_char_i (split_char_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_kind_o  (item_kind_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
